>>> hdl/scsd_pkg.sv
// shared types, command codes and constants for the serial command setpoint decoder
// no dependencies; imported by every other file of the block

package scsd_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_IMPEDANCE = 2'd1,
    MODE_CURRENT   = 2'd2,
    MODE_FULL      = 2'd3
  } mode_t;

  // received ascii command characters
  localparam logic [7:0] CMD_IDLE      = 8'h78; // x
  localparam logic [7:0] CMD_IMPEDANCE = 8'h6D; // m
  localparam logic [7:0] CMD_CURRENT   = 8'h63; // c
  localparam logic [7:0] CMD_FULL      = 8'h66; // f
  localparam logic [7:0] CMD_IMAG_DOWN = 8'h31; // 1
  localparam logic [7:0] CMD_IMAG_ZERO = 8'h32; // 2
  localparam logic [7:0] CMD_IMAG_UP   = 8'h33; // 3
  localparam logic [7:0] CMD_REAL_DOWN = 8'h34; // 4
  localparam logic [7:0] CMD_REAL_ZERO = 8'h35; // 5
  localparam logic [7:0] CMD_REAL_UP   = 8'h36; // 6
  localparam logic [7:0] CMD_DC_DOWN   = 8'h37; // 7
  localparam logic [7:0] CMD_DC_ZERO   = 8'h38; // 8
  localparam logic [7:0] CMD_DC_UP     = 8'h39; // 9
  localparam logic [7:0] CMD_TAN_DOWN  = 8'h71; // q
  localparam logic [7:0] CMD_TAN_ZERO  = 8'h77; // w
  localparam logic [7:0] CMD_TAN_UP    = 8'h65; // e

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_TANPHI_MIN = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TANPHI_MAX = 1'b1;

  localparam logic signed [31:0] TANPHI_MIN_RST = -32'sd1048576;
  localparam logic signed [31:0] TANPHI_MAX_RST = 32'sd1048576;

  // q20 steps: 0.01 truncated and 5.0
  localparam logic signed [31:0] STEP_CURRENT   = 32'sd10485;
  localparam logic signed [31:0] STEP_CURRENT_N = -32'sd10485;
  localparam logic signed [31:0] STEP_TANPHI    = 32'sd10485;
  localparam logic signed [31:0] STEP_TANPHI_N  = -32'sd10485;
  localparam logic [30:0]        STEP_DC        = 31'd5242880;

  localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] imag_cur;
    logic signed [31:0] real_cur;
    logic [30:0]        dc_volt;
    logic signed [31:0] tanphi;
  } setpoints_t;

  typedef struct packed {
    setpoints_t sp;
    logic       known;
  } result_t;

  // signed 32-bit add that sticks at the limits
  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [31:0] d);
    logic [32:0]        s;
    logic signed [31:0] r;
    s = {a[31], a} + {d[31], d};
    if (s[32] != s[31]) begin
      r = s[32] ? INT32_MIN : INT32_MAX;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/scsd_if.sv
// channel interfaces of the serial command setpoint decoder: command bytes,
// results and configuration writes; depends on scsd_pkg

interface scsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface scsd_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operating_state;
  logic signed [31:0] current_imag_target;
  logic signed [31:0] current_real_target;
  logic [30:0]        dc_voltage_target;
  logic signed [31:0] tanphi_target;
  logic               command_known;

  modport source (output valid, output operating_state, output current_imag_target,
                  output current_real_target, output dc_voltage_target,
                  output tanphi_target, output command_known, input ready);
  modport sink (input valid, input operating_state, input current_imag_target,
                input current_real_target, input dc_voltage_target,
                input tanphi_target, input command_known, output ready);
endinterface

interface scsd_cfg_if import scsd_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic signed [31:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/scsd_step.sv
// command decode and setpoint update for one received byte
// depends on scsd_pkg

module scsd_step
  import scsd_pkg::*;
(
  input  logic [7:0]         rx_byte,
  input  setpoints_t         cur,
  input  logic signed [31:0] tanphi_min,
  input  logic signed [31:0] tanphi_max,
  output setpoints_t         nxt,
  output logic               known
);

  logic               not_full;
  logic signed [31:0] imag_dn, imag_up, real_dn, real_up;
  logic signed [31:0] tan_dn, tan_up;
  logic [31:0]        dc_sum;

  assign not_full = (cur.mode != MODE_FULL);
  assign imag_dn  = sat_add32(cur.imag_cur, STEP_CURRENT_N);
  assign imag_up  = sat_add32(cur.imag_cur, STEP_CURRENT);
  assign real_dn  = sat_add32(cur.real_cur, STEP_CURRENT_N);
  assign real_up  = sat_add32(cur.real_cur, STEP_CURRENT);
  assign tan_dn   = sat_add32(cur.tanphi, STEP_TANPHI_N);
  assign tan_up   = sat_add32(cur.tanphi, STEP_TANPHI);
  assign dc_sum   = {1'b0, cur.dc_volt} + {1'b0, STEP_DC};

  always_comb begin
    nxt   = cur;
    known = 1'b1;
    unique case (rx_byte)
      CMD_IDLE:      nxt.mode = MODE_IDLE;
      CMD_IMPEDANCE: nxt.mode = MODE_IMPEDANCE;
      CMD_CURRENT:   nxt.mode = MODE_CURRENT;
      CMD_FULL:      nxt.mode = MODE_FULL;
      CMD_IMAG_DOWN: if (not_full) nxt.imag_cur = imag_dn;
      CMD_IMAG_ZERO: if (not_full) nxt.imag_cur = '0;
      CMD_IMAG_UP:   if (not_full) nxt.imag_cur = imag_up;
      CMD_REAL_DOWN: if (not_full) nxt.real_cur = real_dn;
      CMD_REAL_ZERO: if (not_full) nxt.real_cur = '0;
      CMD_REAL_UP:   if (not_full) nxt.real_cur = real_up;
      // floor at zero
      CMD_DC_DOWN:   nxt.dc_volt = (cur.dc_volt > STEP_DC) ? (cur.dc_volt - STEP_DC) : '0;
      CMD_DC_ZERO:   nxt.dc_volt = '0;
      CMD_DC_UP:     nxt.dc_volt = dc_sum[31] ? '1 : dc_sum[30:0];
      // clamp only on the side the command moves toward
      CMD_TAN_DOWN:  nxt.tanphi = ($signed(tan_dn) < $signed(tanphi_min)) ? tanphi_min : tan_dn;
      CMD_TAN_ZERO:  nxt.tanphi = '0;
      CMD_TAN_UP:    nxt.tanphi = ($signed(tan_up) > $signed(tanphi_max)) ? tanphi_max : tan_up;
      default:       known = 1'b0;
    endcase
  end

endmodule

>>> hdl/scsd_outq.sv
// two-entry result queue: two slots used in turn by write and read pointers
// depends on scsd_pkg

module scsd_outq
  import scsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid & in_ready;
  assign pop       = out_valid & out_ready;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_data;
  end

endmodule

>>> hdl/serial_command_setpoint_decoder.sv
// serial command setpoint decoder: mode and setpoint registers, config limits
// depends on scsd_pkg, scsd_if, scsd_step and scsd_outq
//
// Usage:
// cmd carries one received ascii command byte per beat. Each byte may update the
// operating mode or one setpoint and yields exactly one beat on res holding the
// mode, all four setpoints after the byte, and whether the byte was a command.
// cfg writes the tangent phi limits (index 0 low, index 1 high); it is always
// ready and should be written only while no result is outstanding.
// Each accepted byte's result is registered in the output queue and reaches res
// once earlier results have been taken. Throughput: one byte per cycle while the
// queue has room; the new setpoints are computed from the setpoint registers in
// the cycle the byte is accepted, so back-to-back bytes see each other's effects.
// Results pass through a two-entry queue: when res stalls, one more byte is
// still taken, then cmd.ready drops until res takes a beat.
// Reset (rst, synchronous) sets mode idle, setpoints zero, limits to -1.0/+1.0
// and empties the queue.

module serial_command_setpoint_decoder
  import scsd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  scsd_byte_if.sink       cmd,
  scsd_result_if.source   res,
  scsd_cfg_if.sink        cfg
);

  setpoints_t         sp;
  setpoints_t         sp_next;
  logic               known;
  logic signed [31:0] tanphi_min;
  logic signed [31:0] tanphi_max;
  logic               q_in_ready;
  logic               accept;
  result_t            res_in;
  result_t            res_out;

  assign cfg.ready = 1'b1;
  assign cmd.ready = q_in_ready;
  assign accept    = cmd.valid & q_in_ready;

  scsd_step u_step (
    .rx_byte    (cmd.rx_byte),
    .cur        (sp),
    .tanphi_min (tanphi_min),
    .tanphi_max (tanphi_max),
    .nxt        (sp_next),
    .known      (known)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sp.mode     <= MODE_IDLE;
      sp.imag_cur <= '0;
      sp.real_cur <= '0;
      sp.dc_volt  <= '0;
      sp.tanphi   <= '0;
    end else if (accept) begin
      sp <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tanphi_min <= TANPHI_MIN_RST;
      tanphi_max <= TANPHI_MAX_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TANPHI_MIN: tanphi_min <= cfg.data;
        REG_TANPHI_MAX: tanphi_max <= cfg.data;
        default: ;
      endcase
    end
  end

  assign res_in.sp    = sp_next;
  assign res_in.known = known;

  scsd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (q_in_ready),
    .in_data   (res_in),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (res_out)
  );

  assign res.operating_state     = res_out.sp.mode;
  assign res.current_imag_target = res_out.sp.imag_cur;
  assign res.current_real_target = res_out.sp.real_cur;
  assign res.dc_voltage_target   = res_out.sp.dc_volt;
  assign res.tanphi_target       = res_out.sp.tanphi;
  assign res.command_known       = res_out.known;

endmodule

>>> hdl/scsd_checker.sv
// port-level checks of the serial command setpoint decoder, bound to the top level
// depends on scsd_pkg and serial_command_setpoint_decoder

module scsd_checker
  import scsd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [1:0]         res_state,
  input logic signed [31:0] res_imag,
  input logic signed [31:0] res_real,
  input logic [30:0]        res_dc,
  input logic signed [31:0] res_tanphi,
  input logic               res_known
);

  // nothing comes out of a block just reset
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat right after reset");

  // a stalled result beat holds its payload
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_state) && $stable(res_imag)
      && $stable(res_real) && $stable(res_dc) && $stable(res_tanphi) && $stable(res_known))
    else $error("stalled result beat changed");

  // input back-pressure only when results are waiting
  assert property (@(posedge clk) disable iff (rst) !cmd_ready |-> res_valid)
    else $error("cmd stalled with no result pending");

  // an accepted byte into an empty output shows up the next cycle
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && !res_valid |=> res_valid)
    else $error("accepted byte produced no result");

endmodule

bind serial_command_setpoint_decoder scsd_checker u_scsd_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_state  (res.operating_state),
  .res_imag   (res.current_imag_target),
  .res_real   (res.current_real_target),
  .res_dc     (res.dc_voltage_target),
  .res_tanphi (res.tanphi_target),
  .res_known  (res.command_known)
);
